>>> rtl/mmio_window_run_allocator_assert.svh
// assertion macros for the allocator, empty when synthesised
`ifndef MMIO_WINDOW_RUN_ALLOCATOR_ASSERT_SVH
`define MMIO_WINDOW_RUN_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define MWRA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define MWRA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MWRA_ASSERT_IMP(label, ante, cons, msg)
`define MWRA_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

>>> rtl/mwra_pkg.sv
package mwra_pkg;

  localparam int ENTRY_W = 64;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK = 2'd0;
  localparam status_t ST_BAD_ARG = 2'd1;
  localparam status_t ST_NO_RUN = 2'd2;
  localparam status_t ST_NOT_MAPPED = 2'd3;

  localparam logic OP_MAP = 1'b0;
  localparam logic OP_UNMAP = 1'b1;

  localparam logic [1:0] MODE_UC = 2'd0;
  localparam logic [1:0] MODE_WC = 2'd1;
  localparam logic [1:0] MODE_WB = 2'd2;
  localparam logic [1:0] MODE_BAD = 2'd3;

  localparam logic [11:0] PTE_PRESENT = 12'h001;
  localparam logic [11:0] PTE_WRITE = 12'h002;
  localparam logic [11:0] CACHE_UC = 12'h018;
  localparam logic [11:0] CACHE_WC = 12'h008;
  localparam logic [11:0] CACHE_WB = 12'h000;

  function automatic logic [11:0] cache_bits(logic [1:0] mode);
    logic [11:0] bits;
    case (mode)
      MODE_UC: bits = CACHE_UC;
      MODE_WC: bits = CACHE_WC;
      MODE_WB: bits = CACHE_WB;
      default: bits = 12'h000;
    endcase
    return bits;
  endfunction

endpackage

>>> rtl/mwra_page_store.sv
module mwra_page_store #(
  parameter int WINDOW_PAGES = 1024,
  parameter int IW = (WINDOW_PAGES > 1) ? $clog2(WINDOW_PAGES) : 1
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [IW-1:0]                wr_addr,
  input  logic                         wr_used,
  input  logic [mwra_pkg::ENTRY_W-1:0] wr_entry,
  input  logic [IW-1:0]                rd_addr,
  output logic                         rd_used
);
  import mwra_pkg::*;

  logic                 used_mem [WINDOW_PAGES];
  logic [ENTRY_W-1:0]   entry_mem [WINDOW_PAGES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      used_mem[wr_addr] <= wr_used;
      entry_mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_used <= used_mem[rd_addr];
  end

endmodule

>>> rtl/mmio_window_run_allocator.sv
// channel   | direction | handshake            | payload
// cfg       | in        | cfg_wen              | cfg_wdata (window_base)
// request   | in        | in_valid / in_stall  | op phys_addr virt_addr length_bytes mem_type
// result    | out       | out_valid / out_stall| status mapped_addr
//
// map: checks in S_CHECK, a first-fit scan through the one read port of the used map,
// one write per page in S_MAPWR, then S_FIN to post the result
// unmap: checks in S_CHECK and S_CHECK2, a used check per page, a clear per page, then S_FIN
// after rst a clearing pass over every page runs with in_stall high; cfg writes go on
// in_stall is high from acceptance until the result is loaded; a new item is taken while
// a loaded result still waits under out_stall
module mmio_window_run_allocator #(
  parameter int WINDOW_PAGES = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [63:0]         cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                op,
  input  logic [51:0]         phys_addr,
  input  logic [63:0]         virt_addr,
  input  logic [31:0]         length_bytes,
  input  logic [1:0]          mem_type,
  output logic                out_valid,
  input  logic                out_stall,
  output mwra_pkg::status_t   status,
  output logic [63:0]         mapped_addr
);
  import mwra_pkg::*;

`include "mmio_window_run_allocator_assert.svh"

  localparam int IW = (WINDOW_PAGES > 1) ? $clog2(WINDOW_PAGES) : 1;
  localparam int CW = $clog2(WINDOW_PAGES + 1);
  localparam logic [CW-1:0] WP_LAST = CW'(WINDOW_PAGES - 1);
  localparam logic [20:0] WP21 = 21'(WINDOW_PAGES);
  localparam logic [52:0] WP53 = 53'(WINDOW_PAGES);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_CHECK = 4'd2;
  localparam logic [3:0] S_CHECK2 = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_MAPWR = 4'd5;
  localparam logic [3:0] S_UCHK = 4'd6;
  localparam logic [3:0] S_UCLR = 4'd7;
  localparam logic [3:0] S_FIN = 4'd8;

  logic [3:0]    state;
  logic [63:0]   window_base;
  logic          op_q;
  logic [51:0]   phys_q;
  logic [63:0]   virt_q;
  logic [31:0]   len_q;
  logic [1:0]    mode_q;
  logic [39:0]   frame;
  logic [CW-1:0] pages;
  logic [CW-1:0] run;
  logic [IW-1:0] start;
  logic [CW-1:0] scan_rd;
  logic [CW-1:0] wcnt;
  logic [51:0]   diff_hi;
  logic          borrow;
  status_t       res_status;

  logic [19:0]   len_pages;
  logic          len_bad;
  logic [52:0]   phys_end;
  logic          phys_over;
  logic          map_bad;
  logic [64:0]   diff;
  logic [52:0]   unmap_end;
  logic [CW-1:0] p;
  logic [CW-1:0] run_inc;

  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic                 wr_used;
  logic [ENTRY_W-1:0]   wr_entry;
  logic [IW-1:0]        rd_addr;
  logic                 used_q;

  assign len_pages = len_q[31:12];
  assign len_bad = (len_q == 32'd0) || (len_q[11:0] != 12'd0);
  assign phys_end = {1'b0, phys_q} + 53'(len_q);
  assign phys_over = phys_end[52] && (phys_end[51:0] != 52'd0);
  assign map_bad = len_bad || (phys_q[11:0] != 12'd0) || ({1'b0, len_pages} > WP21) ||
                   phys_over || (mode_q == MODE_BAD);
  assign diff = {1'b0, virt_q} - {1'b0, window_base[63:12], 12'd0};
  assign unmap_end = {1'b0, diff_hi} + 53'(len_pages);
  assign p = scan_rd - CW'(1);
  assign run_inc = run + CW'(1);

  assign in_stall = (state != S_IDLE);

  always_comb begin
    wr_en = 1'b0;
    wr_used = 1'b0;
    wr_entry = '0;
    wr_addr = start + wcnt[IW-1:0];
    rd_addr = '0;
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = wcnt[IW-1:0];
      end
      S_MAPWR: begin
        wr_en = 1'b1;
        wr_used = 1'b1;
        wr_entry = {1'b1, 11'd0, frame, cache_bits(mode_q) | PTE_WRITE | PTE_PRESENT};
      end
      S_UCLR: wr_en = 1'b1;
      S_SCAN: rd_addr = scan_rd[IW-1:0];
      S_UCHK: rd_addr = start + scan_rd[IW-1:0];
      default: wr_en = 1'b0;
    endcase
  end

  mwra_page_store #(
    .WINDOW_PAGES(WINDOW_PAGES),
    .IW(IW)
  ) u_store (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_used(wr_used),
    .wr_entry(wr_entry),
    .rd_addr(rd_addr),
    .rd_used(used_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_base <= 64'd0;
    end else if (cfg_wen) begin
      window_base <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      wcnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          wcnt <= wcnt + CW'(1);
          if (wcnt == WP_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_q <= op;
            phys_q <= phys_addr;
            virt_q <= virt_addr;
            len_q <= length_bytes;
            mode_q <= mem_type;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          pages <= len_pages[CW-1:0];
          scan_rd <= '0;
          run <= '0;
          frame <= phys_q[51:12];
          diff_hi <= diff[63:12];
          borrow <= diff[64];
          if (op_q == OP_MAP) begin
            if (map_bad) begin
              res_status <= ST_BAD_ARG;
              state <= S_FIN;
            end else begin
              state <= S_SCAN;
            end
          end else if (len_bad || (virt_q[11:0] != 12'd0)) begin
            res_status <= ST_BAD_ARG;
            state <= S_FIN;
          end else begin
            state <= S_CHECK2;
          end
        end
        S_CHECK2: begin
          if (borrow || (unmap_end > WP53)) begin
            res_status <= ST_BAD_ARG;
            state <= S_FIN;
          end else begin
            start <= diff_hi[IW-1:0];
            state <= S_UCHK;
          end
        end
        S_SCAN: begin
          scan_rd <= scan_rd + CW'(1);
          if (scan_rd != '0) begin
            if (!used_q) begin
              if (run == '0) begin
                start <= p[IW-1:0];
              end
              run <= run_inc;
              if (run_inc == pages) begin
                wcnt <= '0;
                state <= S_MAPWR;
              end else if (p == WP_LAST) begin
                res_status <= ST_NO_RUN;
                state <= S_FIN;
              end
            end else begin
              run <= '0;
              if (p == WP_LAST) begin
                res_status <= ST_NO_RUN;
                state <= S_FIN;
              end
            end
          end
        end
        S_MAPWR: begin
          wcnt <= wcnt + CW'(1);
          frame <= frame + 40'd1;
          if (wcnt == pages - CW'(1)) begin
            res_status <= ST_OK;
            state <= S_FIN;
          end
        end
        S_UCHK: begin
          scan_rd <= scan_rd + CW'(1);
          if (scan_rd != '0) begin
            if (!used_q) begin
              res_status <= ST_NOT_MAPPED;
              state <= S_FIN;
            end else if (scan_rd == pages) begin
              wcnt <= '0;
              state <= S_UCLR;
            end
          end
        end
        S_UCLR: begin
          wcnt <= wcnt + CW'(1);
          if (wcnt == pages - CW'(1)) begin
            res_status <= ST_OK;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status <= res_status;
            if ((res_status == ST_OK) && (op_q == OP_MAP)) begin
              mapped_addr <= {window_base[63:12] + 52'(start), 12'd0};
            end else begin
              mapped_addr <= 64'd0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MWRA_ASSERT_IMP(a_run_below_pages, state == S_SCAN, run < pages, "run reached length inside scan")
  `MWRA_ASSERT_IMP(a_write_in_window, (state == S_MAPWR) || (state == S_UCLR), (32'(start) + 32'(wcnt)) < 32'(WINDOW_PAGES), "page write past window")
  `MWRA_ASSERT_NXT(a_take_to_check, in_valid && !in_stall, state == S_CHECK, "accepted item not checked")
  `MWRA_ASSERT_NXT(a_fin_loads, (state == S_FIN) && (!out_valid || !out_stall), out_valid && (state == S_IDLE), "result not loaded")

endmodule
